// File: hdl/vpbb_pkg.sv
package vpbb_pkg;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_TARGET    = 2'd1;
    localparam logic [1:0] CMD_CALIBRATE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_PRECISION   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_HYSTERESIS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_DELTA     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_NEEDED    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAUSE_SAMPLES    = 3'd4;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_CTRL,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_OPENING = 2'd1,
        PH_PAUSE   = 2'd2,
        PH_CLOSING = 2'd3
    } phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hdl/vpbb_if.sv
interface vpbb_in_if #(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [SAMPLE_BITS-1:0]   sample;
    logic [FRACTION_BITS:0]   target;

    modport source (output valid, output command, output sample, output target, input ready);
    modport sink   (input valid, input command, input sample, input target, output ready);
endinterface

interface vpbb_out_if #(
    parameter int FRACTION_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic                     open_relay;
    logic                     close_relay;
    logic [FRACTION_BITS:0]   position;
    logic                     is_calibrated;
    logic                     is_calibrating;

    modport source (output valid, output open_relay, output close_relay, output position,
                    output is_calibrated, output is_calibrating, input ready);
    modport sink   (input valid, input open_relay, input close_relay, input position,
                    input is_calibrated, input is_calibrating, output ready);
endinterface

interface vpbb_cfg_if #(
    parameter int DATA_BITS = 13
);
    logic                                 valid;
    logic                                 ready;
    logic [vpbb_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [DATA_BITS-1:0]                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/valve_position_bang_bang_controller.sv
// sample under control: the request passes S_EXEC, then S_DIV, where the serial divider
// gives one quotient bit per cycle, then S_CTRL and S_FINISH, which registers the result;
// S_DIV is skipped for a zero or saturated scaling; other requests: S_EXEC, S_FINISH;
// one request at a time; the next is taken the cycle after the result is registered
// rst_n is asynchronous active low: control and configuration registers return to their
// defaults, valve stopped, uncalibrated, no calibration run
module valve_position_bang_bang_controller #(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    vpbb_in_if.sink    in,
    vpbb_out_if.source out,
    vpbb_cfg_if.sink   cfg
);
    import vpbb_pkg::*;

    localparam int POS_BITS  = FRACTION_BITS + 1;
    localparam int DIFF_BITS = FRACTION_BITS + 3;
    localparam logic [POS_BITS-1:0] ONE_FRAC = POS_BITS'(1) << FRACTION_BITS;

    state_t state_reg, state_next;

    // configuration
    logic [POS_BITS-1:0]     stop_prec_reg;
    logic [POS_BITS-1:0]     start_hyst_reg;
    logic [SAMPLE_BITS-1:0]  stable_delta_reg;
    logic [7:0]              stable_needed_reg;
    logic [7:0]              pause_samples_reg;

    // request capture
    logic [1:0]              cmd_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [POS_BITS-1:0]     target_in_reg;

    // controller state
    logic [SAMPLE_BITS-1:0]  open_end_reg, open_end_next;
    logic [SAMPLE_BITS-1:0]  closed_end_reg, closed_end_next;
    logic [POS_BITS-1:0]     target_reg, target_next;
    logic [POS_BITS-1:0]     position_reg, position_next;
    dir_t                    dir_reg, dir_next;
    logic                    calibrated_reg, calibrated_next;
    phase_t                  phase_reg, phase_next;
    logic [SAMPLE_BITS-1:0]  prev_reg, prev_next;
    logic                    prev_valid_reg, prev_valid_next;
    logic [7:0]              stable_cnt_reg, stable_cnt_next;
    logic [7:0]              pause_cnt_reg, pause_cnt_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_open_reg, out_close_reg, out_cal_reg, out_caling_reg;
    logic [POS_BITS-1:0]     out_pos_reg;
    logic                    load_out;

    // divider
    logic                      div_start;
    logic [SAMPLE_BITS-1:0]    div_num, div_den;
    logic [FRACTION_BITS-1:0]  div_quo;
    div_stat_t                 div_stat;

    // scaling and stable detection terms
    logic signed [SAMPLE_BITS:0] n_val, d_val;
    logic [SAMPLE_BITS:0]        n_abs, d_abs;
    logic                        scale_zero;
    logic [SAMPLE_BITS-1:0]      read_diff;
    logic [7:0]                  stable_cnt_step;
    logic                        stable_hit;
    logic [7:0]                  pause_cnt_step;
    logic signed [DIFF_BITS-1:0] err, prec_s, hyst_s;

    vpbb_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign in.ready  = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_prec_reg     <= POS_BITS'(41);
            start_hyst_reg    <= POS_BITS'(82);
            stable_delta_reg  <= SAMPLE_BITS'(10);
            stable_needed_reg <= 8'd15;
            pause_samples_reg <= 8'd20;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_STOP_PRECISION:   stop_prec_reg     <= cfg.data[POS_BITS-1:0];
                REG_START_HYSTERESIS: start_hyst_reg    <= cfg.data[POS_BITS-1:0];
                REG_STABLE_DELTA:     stable_delta_reg  <= cfg.data[SAMPLE_BITS-1:0];
                REG_STABLE_NEEDED:    stable_needed_reg <= cfg.data[7:0];
                REG_PAUSE_SAMPLES:    pause_samples_reg <= cfg.data[7:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            cmd_reg       <= in.command;
            sample_reg    <= in.sample;
            target_in_reg <= in.target;
        end
        if (load_out)
        begin
            out_open_reg   <= (dir_reg == DIR_OPEN);
            out_close_reg  <= (dir_reg == DIR_CLOSE);
            out_pos_reg    <= position_reg;
            out_cal_reg    <= calibrated_reg;
            out_caling_reg <= (phase_reg != PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            open_end_reg   <= '0;
            closed_end_reg <= '0;
            target_reg     <= '0;
            position_reg   <= '0;
            dir_reg        <= DIR_STOP;
            calibrated_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            stable_cnt_reg <= '0;
            pause_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            open_end_reg   <= open_end_next;
            closed_end_reg <= closed_end_next;
            target_reg     <= target_next;
            position_reg   <= position_next;
            dir_reg        <= dir_next;
            calibrated_reg <= calibrated_next;
            phase_reg      <= phase_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            stable_cnt_reg <= stable_cnt_next;
            pause_cnt_reg  <= pause_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        n_val = $signed({1'b0, sample_reg}) - $signed({1'b0, closed_end_reg});
        d_val = $signed({1'b0, open_end_reg}) - $signed({1'b0, closed_end_reg});
        n_abs = n_val[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-n_val) : n_val;
        d_abs = d_val[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_val) : d_val;
        scale_zero = (d_val == '0) || (n_val == '0) || (n_val[SAMPLE_BITS] != d_val[SAMPLE_BITS]);

        read_diff = (sample_reg > prev_reg) ? (sample_reg - prev_reg) : (prev_reg - sample_reg);
        if (prev_valid_reg && (read_diff < stable_delta_reg))
            stable_cnt_step = (stable_cnt_reg == COUNT_MAX) ? COUNT_MAX : stable_cnt_reg + 8'd1;
        else
            stable_cnt_step = '0;
        stable_hit = (stable_cnt_step >= stable_needed_reg);
        pause_cnt_step = (pause_cnt_reg == COUNT_MAX) ? COUNT_MAX : pause_cnt_reg + 8'd1;

        err    = $signed({2'b00, target_reg}) - $signed({2'b00, position_reg});
        prec_s = $signed({2'b00, stop_prec_reg});
        hyst_s = $signed({2'b00, start_hyst_reg});
    end

    always_comb
    begin
        state_next      = state_reg;
        open_end_next   = open_end_reg;
        closed_end_next = closed_end_reg;
        target_next     = target_reg;
        position_next   = position_reg;
        dir_next        = dir_reg;
        calibrated_next = calibrated_reg;
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        stable_cnt_next = stable_cnt_reg;
        pause_cnt_next  = pause_cnt_reg;
        div_start       = 1'b0;
        div_num         = n_abs[SAMPLE_BITS-1:0];
        div_den         = d_abs[SAMPLE_BITS-1:0];
        load_out        = 1'b0;
        out_valid_next  = out_valid_reg && !out.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                case (cmd_reg)
                    CMD_SAMPLE:
                    begin
                        case (phase_reg)
                            PH_OPENING, PH_CLOSING:
                            begin
                                stable_cnt_next = stable_cnt_step;
                                if (stable_hit)
                                begin
                                    dir_next = DIR_STOP;
                                    if (phase_reg == PH_OPENING)
                                    begin
                                        open_end_next  = sample_reg;
                                        pause_cnt_next = '0;
                                        if (pause_samples_reg == '0)
                                        begin
                                            phase_next      = PH_CLOSING;
                                            dir_next        = DIR_CLOSE;
                                            prev_valid_next = 1'b0;
                                            prev_next       = '0;
                                            stable_cnt_next = '0;
                                        end
                                        else
                                            phase_next = PH_PAUSE;
                                    end
                                    else
                                    begin
                                        closed_end_next = sample_reg;
                                        phase_next      = PH_IDLE;
                                        calibrated_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    prev_next       = sample_reg;
                                    prev_valid_next = 1'b1;
                                end
                            end
                            PH_PAUSE:
                            begin
                                pause_cnt_next = pause_cnt_step;
                                if (pause_cnt_step >= pause_samples_reg)
                                begin
                                    phase_next      = PH_CLOSING;
                                    dir_next        = DIR_CLOSE;
                                    prev_valid_next = 1'b0;
                                    prev_next       = '0;
                                    stable_cnt_next = '0;
                                end
                            end
                            default:
                            begin
                                if (calibrated_reg)
                                begin
                                    // trivial scalings skip the divider
                                    if (scale_zero)
                                    begin
                                        position_next = '0;
                                        state_next    = S_CTRL;
                                    end
                                    else if (n_abs >= d_abs)
                                    begin
                                        position_next = ONE_FRAC;
                                        state_next    = S_CTRL;
                                    end
                                    else
                                    begin
                                        div_start  = 1'b1;
                                        state_next = S_DIV;
                                    end
                                end
                            end
                        endcase
                    end
                    CMD_TARGET:
                    begin
                        if (calibrated_reg)
                            target_next = (target_in_reg > ONE_FRAC) ? ONE_FRAC : target_in_reg;
                    end
                    CMD_CALIBRATE:
                    begin
                        phase_next      = PH_OPENING;
                        dir_next        = DIR_OPEN;
                        prev_valid_next = 1'b0;
                        prev_next       = '0;
                        stable_cnt_next = '0;
                        pause_cnt_next  = '0;
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    position_next = {1'b0, div_quo};
                    state_next    = S_CTRL;
                end
            end
            S_CTRL:
            begin
                state_next = S_FINISH;
                case (dir_reg)
                    DIR_OPEN:
                    begin
                        if (err <= prec_s)
                            dir_next = DIR_STOP;
                    end
                    DIR_CLOSE:
                    begin
                        if (err >= -prec_s)
                            dir_next = DIR_STOP;
                    end
                    default:
                    begin
                        if (err > hyst_s)
                            dir_next = DIR_OPEN;
                        else if (err < -hyst_s)
                            dir_next = DIR_CLOSE;
                    end
                endcase
            end
            S_FINISH:
            begin
                // wait for the result slot to free up
                if (!out_valid_reg || out.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out.valid          = out_valid_reg;
    assign out.open_relay     = out_open_reg;
    assign out.close_relay    = out_close_reg;
    assign out.position       = out_pos_reg;
    assign out.is_calibrated  = out_cal_reg;
    assign out.is_calibrating = out_caling_reg;

endmodule

// File: hdl/vpbb_div.sv
module vpbb_div #(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SAMPLE_BITS-1:0]    dividend,
    input  logic [SAMPLE_BITS-1:0]    divisor,
    output logic [FRACTION_BITS-1:0]  quotient,
    output vpbb_pkg::div_stat_t       stat
);
    import vpbb_pkg::*;

    localparam int STEP_BITS = $clog2(FRACTION_BITS + 1);

    // restoring division, one quotient bit a cycle; dividend is below divisor
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [STEP_BITS-1:0]      count_reg, count_next;
    logic [SAMPLE_BITS-1:0]    rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]    dvs_reg, dvs_next;
    logic [FRACTION_BITS-1:0]  quo_reg, quo_next;
    logic [SAMPLE_BITS:0]      shifted;
    logic [SAMPLE_BITS:0]      trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        shifted    = {rem_reg, 1'b0};
        trial      = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = STEP_BITS'(FRACTION_BITS);
            rem_next   = dividend;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[SAMPLE_BITS-1:0];
                quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SAMPLE_BITS-1:0];
                quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b0};
            end
            count_next = count_reg - STEP_BITS'(1);
            if (count_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
